@@ design/b64le_pkg.sv @@
package b64le_pkg;

  localparam logic [7:0] NL_CODE         = 8'd10;
  localparam logic [7:0] PAD_CODE        = 8'd61;
  localparam logic [7:0] LINE_LENGTH_RST = 8'd76;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // group byte counts
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_TWO   = 2'd2;
  localparam logic [1:0] CNT_THREE = 2'd3;

  // one input group, left-aligned in 24 bits
  typedef struct packed {
    logic [23:0] block;
    logic [1:0]  count;
    logic        eos;
  } group_t;

  function automatic logic [7:0] b64_symbol(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'd71 + {2'b00, v};   // 'a' - 26
    end else if (v < 6'd62) begin
      r = {2'b00, v} - 8'd4;    // '0' - 52
    end else if (v == 6'd62) begin
      r = 8'd43;                // '+'
    end else begin
      r = 8'd47;                // '/'
    end
    return r;
  endfunction

endpackage

@@ design/base64_line_encoder_core.sv @@
// Output: a byte that closes a group (third byte or end of stream) is queued,
//   then loaded into the back end's group register and shown through the output
//   register when the back end is idle; other bytes give no output.
// Throughput: one byte per cycle in while the group queue has room; one
//   character per cycle out while out_ready_i does not stall it, so a group
//   gives four characters plus any wrap and closing newlines.
// Reset (rst_ni low, async): line length back to 76, no pending bytes, column 0,
//   queue and output register empty.
module base64_line_encoder_core #(
  parameter int unsigned QueueDepth = b64le_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // byte input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_value_i,
  input  logic       end_of_stream_i,
  // character output channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] char_code_o,
  output logic       last_of_run_o,
  // line length register write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] line_length_i
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [7:0]        line_len_q;
  logic              push, full, pop, q_valid;
  b64le_pkg::group_t push_grp, pop_grp;
  logic [CntW-1:0]   q_count;

  // Register writes always land; the user must issue them only while idle, the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q <= b64le_pkg::LINE_LENGTH_RST;
    end else if (cfg_valid_i) begin
      line_len_q <= line_length_i;
    end
  end

  // Front: gathers bytes into groups of up to three.
  b64le_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .byte_value_i    (byte_value_i),
    .end_of_stream_i (end_of_stream_i),
    .push_o          (push),
    .group_o         (push_grp),
    .full_i          (full)
  );

  // Group queue decouples byte intake from character output.
  b64le_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_grp),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pop_grp),
    .count_o (q_count)
  );

  // Back: one character per cycle while the output is not stalled, wrap newlines, padding, closing newline.
  b64le_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .line_length_i (line_len_q),
    .q_valid_i     (q_valid),
    .q_data_i      (pop_grp),
    .q_pop_o       (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .char_code_o   (char_code_o),
    .last_of_run_o (last_of_run_o)
  );

  // A closing byte must leave a group in the queue.
  a_eos_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && end_of_stream_i) |=> (q_count != '0))
    else $error("end-of-stream group not queued");

  // Intake stalls only on a full queue.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (q_count == CntW'(QueueDepth)))
    else $error("intake stalled with queue room");

  // Two newlines never follow each other.
  a_no_double_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && (char_code_o == b64le_pkg::NL_CODE)) |=>
    !(out_valid_o && (char_code_o == b64le_pkg::NL_CODE)))
    else $error("back-to-back newlines");

endmodule

@@ design/b64le_front.sv @@
module b64le_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          byte_value_i,
  input  logic                end_of_stream_i,
  output logic                push_o,
  output b64le_pkg::group_t   group_o,
  input  logic                full_i
);

  logic [15:0] pend_q, pend_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        acc;
  logic        close;

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign close      = end_of_stream_i || (cnt_q == 2'd2);

  always_comb begin
    group_o.eos   = end_of_stream_i;
    group_o.count = cnt_q + 2'd1;
    case (cnt_q)
      2'd0:    group_o.block = {byte_value_i, 16'h0000};
      2'd1:    group_o.block = {pend_q[7:0], byte_value_i, 8'h00};
      default: group_o.block = {pend_q, byte_value_i};
    endcase
  end

  assign push_o = acc && close;

  always_comb begin
    pend_d = pend_q;
    cnt_d  = cnt_q;
    if (acc) begin
      if (close) begin
        pend_d = 16'h0000;
        cnt_d  = 2'd0;
      end else begin
        pend_d = {pend_q[7:0], byte_value_i};
        cnt_d  = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

@@ design/b64le_queue.sv @@
module b64le_queue #(
  parameter int unsigned Depth = b64le_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  b64le_pkg::group_t          data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic                       valid_o,
  output b64le_pkg::group_t          data_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64le_pkg::group_t mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ design/b64le_back.sv @@
module b64le_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          line_length_i,
  input  logic                q_valid_i,
  input  b64le_pkg::group_t   q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          char_code_o,
  output logic                last_of_run_o
);

  b64le_pkg::group_t grp_q;
  logic        busy_q, busy_d;
  logic [1:0]  step_q, step_d;
  logic        nl_q, nl_d;      // wrap newline due
  logic        fin_q, fin_d;    // closing newline due
  logic        done_q, done_d;  // all four characters out
  logic [7:0]  col_q, col_d;
  logic        ov_q, ov_d;
  logic [7:0]  chr_q, chr_d;
  logic        last_q, last_d;

  logic        emit, finish, load;
  logic [8:0]  limit, col_nx;
  logic        wrap;
  logic [5:0]  sextet;
  logic        pad;
  logic [7:0]  sym;

  assign emit   = busy_q && (!ov_q || out_ready_i);
  assign limit  = (line_length_i == 8'd0) ? 9'd256 : {1'b0, line_length_i};
  assign col_nx = {1'b0, col_q} + 9'd1;
  assign wrap   = (col_nx >= limit);

  always_comb begin
    case (step_q)
      2'd0:    sextet = grp_q.block[23:18];
      2'd1:    sextet = grp_q.block[17:12];
      2'd2:    sextet = grp_q.block[11:6];
      default: sextet = grp_q.block[5:0];
    endcase
  end

  assign pad = ((step_q == 2'd2) && (grp_q.count == b64le_pkg::CNT_ONE)) ||
               ((step_q == 2'd3) && (grp_q.count != b64le_pkg::CNT_THREE));
  assign sym = pad ? b64le_pkg::PAD_CODE : b64le_pkg::b64_symbol(sextet);

  always_comb begin
    step_d = step_q;
    nl_d   = nl_q;
    fin_d  = fin_q;
    done_d = done_q;
    col_d  = col_q;
    chr_d  = chr_q;
    last_d = last_q;
    finish = 1'b0;
    if (emit) begin
      if (nl_q) begin
        chr_d  = b64le_pkg::NL_CODE;
        nl_d   = 1'b0;
        last_d = done_q;
        finish = done_q;
      end else if (fin_q) begin
        chr_d  = b64le_pkg::NL_CODE;
        fin_d  = 1'b0;
        col_d  = 8'd0;
        last_d = 1'b1;
        finish = 1'b1;
      end else begin
        chr_d  = sym;
        last_d = 1'b0;
        if (wrap) begin
          col_d = 8'd0;
          nl_d  = 1'b1;
        end else begin
          col_d = col_nx[7:0];
        end
        if (step_q == 2'd3) begin
          if (wrap) begin
            done_d = 1'b1;
          end else if (grp_q.eos) begin
            fin_d = 1'b1;
          end else begin
            last_d = 1'b1;
            finish = 1'b1;
          end
        end else begin
          step_d = step_q + 2'd1;
        end
      end
    end
  end

  assign load    = q_valid_i && (!busy_q || finish);
  assign q_pop_o = load;

  always_comb begin
    busy_d = busy_q;
    if (load) begin
      busy_d = 1'b1;
    end else if (finish) begin
      busy_d = 1'b0;
    end
    if (emit) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      grp_q <= q_data_i;
    end
    chr_q  <= chr_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      nl_q   <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      col_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ov_q   <= ov_d;
      col_q  <= col_d;
      if (load) begin
        step_q <= '0;
        nl_q   <= 1'b0;
        fin_q  <= 1'b0;
        done_q <= 1'b0;
      end else begin
        step_q <= step_d;
        nl_q   <= nl_d;
        fin_q  <= fin_d;
        done_q <= done_d;
      end
    end
  end

  assign out_valid_o   = ov_q;
  assign char_code_o   = chr_q;
  assign last_of_run_o = last_q;

endmodule
